[rtl/core/stx_etx_packet_deframer_unit_assert.svh]
// Assertion macros for the deframer RTL, used by stxd_core.
// No dependencies; each macro is empty when SYNTH is defined.
`ifndef STX_ETX_PACKET_DEFRAMER_UNIT_ASSERT_SVH
`define STX_ETX_PACKET_DEFRAMER_UNIT_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define STXD_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("stxd: implication check failed");
// next-cycle implication
`define STXD_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("stxd: next-cycle check failed");
`else
`define STXD_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs)
`define STXD_ASSERT_NEXT(label, clk, rst_n, lhs, rhs)
`endif

`endif

[rtl/core/stxd_pkg.sv]
// Types and constants for the start/end-marker packet deframer.
// No dependencies.
`timescale 1ns / 1ps
package stxd_pkg;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_HEADER = 3'd1,
        PH_DATA   = 3'd2,
        PH_CHECK  = 3'd3,
        PH_END    = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_DATA   = 3'd1,
        EV_GOOD   = 3'd2,
        EV_LENBAD = 3'd3,
        EV_SUMBAD = 3'd4,
        EV_ENDBAD = 3'd5
    } t_event;

    localparam logic [1:0] CFG_EXP_LEN   = 2'd0;
    localparam logic [1:0] CFG_START     = 2'd1;
    localparam logic [1:0] CFG_END       = 2'd2;

    localparam logic [7:0] RST_EXP_LEN   = 8'd255;
    localparam logic [7:0] RST_START     = 8'd2;
    localparam logic [7:0] RST_END       = 8'd3;

    localparam logic [1:0] HDR_STATUS    = 2'd0;
    localparam logic [1:0] HDR_TYPE      = 2'd1;
    localparam logic [1:0] HDR_LENGTH    = 2'd2;

    typedef struct packed {
        logic [7:0] exp_len;
        logic [7:0] start_mark;
        logic [7:0] end_mark;
    } t_cfg;

    typedef struct packed {
        t_event     event_res;
        logic [7:0] data_byte;
        logic [7:0] frame_type;
        logic [7:0] status_byte;
    } t_result;

endpackage

[rtl/core/stxd_in_stage.sv]
// Input register of the deframer: holds one received byte beat.
// Depends on nothing outside this file.
`timescale 1ns / 1ps
module stxd_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    // refill in the same cycle the held beat moves on
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

endmodule

[rtl/core/stxd_core.sv]
// Deframing state machine: phase, header, payload count and running sum.
// Depends on stxd_pkg and the assertion macro header.
`timescale 1ns / 1ps
module stxd_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  logic [7:0]       i_byte,
    input  stxd_pkg::t_cfg   i_cfg,
    output stxd_pkg::t_result o_res
);
    import stxd_pkg::*;
    `include "stx_etx_packet_deframer_unit_assert.svh"

    t_phase     r_phase,  n_phase;
    logic [1:0] r_hdr_cnt, n_hdr_cnt;
    logic [7:0] r_pay_cnt, n_pay_cnt;
    logic [7:0] r_sum,    n_sum;
    logic [7:0] r_status, n_status;
    logic [7:0] r_type,   n_type;
    logic [7:0] pay_inc;

    assign pay_inc = r_pay_cnt + 8'd1;

    // next state
    always_comb begin
        n_phase   = r_phase;
        n_hdr_cnt = r_hdr_cnt;
        n_pay_cnt = r_pay_cnt;
        n_sum     = r_sum;
        n_status  = r_status;
        n_type    = r_type;
        unique case (r_phase)
            PH_HUNT: begin
                if (i_byte == i_cfg.start_mark) begin
                    n_phase   = PH_HEADER;
                    n_hdr_cnt = HDR_STATUS;
                    n_sum     = 8'd0;
                end
            end
            PH_HEADER: begin
                n_sum = r_sum + i_byte;
                if (r_hdr_cnt == HDR_STATUS) begin
                    n_status  = i_byte;
                    n_hdr_cnt = HDR_TYPE;
                end else if (r_hdr_cnt == HDR_TYPE) begin
                    n_type    = i_byte;
                    n_hdr_cnt = HDR_LENGTH;
                end else begin
                    n_hdr_cnt = HDR_STATUS;
                    if (i_byte != i_cfg.exp_len) begin
                        n_phase = PH_HUNT;
                    end else begin
                        n_pay_cnt = 8'd0;
                        // zero-length packet goes straight to the checksum
                        n_phase   = (i_byte == 8'd0) ? PH_CHECK : PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                n_sum     = r_sum + i_byte;
                n_pay_cnt = pay_inc;
                if (pay_inc == i_cfg.exp_len) begin
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                n_phase = (i_byte == r_sum) ? PH_END : PH_HUNT;
            end
            PH_END: begin
                n_phase = PH_HUNT;
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    // result of this beat
    always_comb begin
        o_res.event_res   = EV_NONE;
        o_res.data_byte   = 8'd0;
        o_res.frame_type  = n_type;
        o_res.status_byte = n_status;
        unique case (r_phase)
            PH_HEADER: begin
                if (r_hdr_cnt != HDR_STATUS && r_hdr_cnt != HDR_TYPE &&
                    i_byte != i_cfg.exp_len) begin
                    o_res.event_res = EV_LENBAD;
                end
            end
            PH_DATA: begin
                o_res.event_res = EV_DATA;
                o_res.data_byte = i_byte;
            end
            PH_CHECK: begin
                if (i_byte != r_sum) begin
                    o_res.event_res = EV_SUMBAD;
                end
            end
            PH_END: begin
                o_res.event_res = (i_byte == i_cfg.end_mark) ? EV_GOOD : EV_ENDBAD;
            end
            default: begin
                o_res.event_res = EV_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_hdr_cnt <= HDR_STATUS;
            r_pay_cnt <= 8'd0;
            r_sum     <= 8'd0;
            r_status  <= 8'd0;
            r_type    <= 8'd0;
        end else if (i_take) begin
            r_phase   <= n_phase;
            r_hdr_cnt <= n_hdr_cnt;
            r_pay_cnt <= n_pay_cnt;
            r_sum     <= n_sum;
            r_status  <= n_status;
            r_type    <= n_type;
        end
    end

    `STXD_ASSERT_NEXT(a_hold_idle, i_clk, i_rst_n, !i_take, $stable(r_phase))
    `STXD_ASSERT_NEXT(a_end_to_hunt, i_clk, i_rst_n,
        i_take && r_phase == PH_END, r_phase == PH_HUNT)
    `STXD_ASSERT_NEXT(a_data_exit, i_clk, i_rst_n,
        i_take && r_phase == PH_DATA, r_phase == PH_DATA || r_phase == PH_CHECK)
    `STXD_ASSERT_IMPLY(a_hdr_range, i_clk, i_rst_n, r_phase == PH_HEADER, r_hdr_cnt != 2'd3)

endmodule

[rtl/core/stxd_out_stage.sv]
// Result register of the deframer: holds one result beat until taken.
// Depends on stxd_pkg.
`timescale 1ns / 1ps
module stxd_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  stxd_pkg::t_result i_res,
    output logic              o_valid,
    input  logic              i_ready,
    output stxd_pkg::t_result o_res
);
    import stxd_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= i_res;
        end
    end

endmodule

[rtl/core/stx_etx_packet_deframer_unit.sv]
// Start/end-marker packet deframer with 8-bit sum checksum.
// Path from input beat to result beat: input register, state logic, result register.
// Throughput one byte beat per cycle while the result side is ready; one result beat for every byte beat.
// Synchronous active-low reset: hunting for the start byte, counters and held header zero,
// expected length 255, start marker 2, end marker 3.
// Depends on stxd_pkg, stxd_in_stage, stxd_core and stxd_out_stage.
`timescale 1ns / 1ps
module stx_etx_packet_deframer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_event_res,
    output logic [7:0] o_data_byte,
    output logic [7:0] o_frame_type,
    output logic [7:0] o_status_byte,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_wdata
);
    import stxd_pkg::*;

    t_cfg       r_cfg;
    logic       in_valid;
    logic [7:0] in_byte;
    logic       out_ready;
    logic       take;
    t_result    core_res;
    t_result    out_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.exp_len    <= RST_EXP_LEN;
            r_cfg.start_mark <= RST_START;
            r_cfg.end_mark   <= RST_END;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_EXP_LEN: r_cfg.exp_len    <= i_cfg_wdata;
                CFG_START:   r_cfg.start_mark <= i_cfg_wdata;
                CFG_END:     r_cfg.end_mark   <= i_cfg_wdata;
                default:     r_cfg            <= r_cfg;
            endcase
        end
    end

    assign take = in_valid && out_ready;

    stxd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_byte  (i_rx_byte),
        .i_take  (take),
        .o_valid (in_valid),
        .o_byte  (in_byte)
    );

    stxd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (in_byte),
        .i_cfg   (r_cfg),
        .o_res   (core_res)
    );

    stxd_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_valid),
        .o_ready (out_ready),
        .i_res   (core_res),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (out_res)
    );

    assign o_event_res   = out_res.event_res;
    assign o_data_byte   = out_res.data_byte;
    assign o_frame_type  = out_res.frame_type;
    assign o_status_byte = out_res.status_byte;

endmodule

[tb/stx_etx_packet_deframer_unit_tb.sv]
// Self-checking testbench for stx_etx_packet_deframer_unit.
// Depends on stxd_pkg; predicts each result beat and checks it field by field.
`timescale 1ns / 1ps
module stx_etx_packet_deframer_unit_tb;
    import stxd_pkg::*;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int RAND_ITEMS   = 1100;
    localparam int PHASE_ITEMS  = 120;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int REPORT_LIMIT = 200;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [7:0] i_rx_byte = 8'd0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [2:0] o_event_res;
    logic [7:0] o_data_byte;
    logic [7:0] o_frame_type;
    logic [7:0] o_status_byte;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_index = 2'd0;
    logic [7:0] i_cfg_wdata = 8'd0;

    stx_etx_packet_deframer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_rx_byte     (i_rx_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_event_res   (o_event_res),
        .o_data_byte   (o_data_byte),
        .o_frame_type  (o_frame_type),
        .o_status_byte (o_status_byte),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    // predictor state, reset values
    t_phase     dfr_phase   = PH_HUNT;
    logic [1:0] hdr_cnt     = HDR_STATUS;
    logic [7:0] pay_cnt     = 8'd0;
    logic [7:0] sum_acc     = 8'd0;
    logic [7:0] hold_status = 8'd0;
    logic [7:0] hold_type   = 8'd0;
    logic [7:0] cfg_len     = RST_EXP_LEN;
    logic [7:0] cfg_start   = RST_START;
    logic [7:0] cfg_end     = RST_END;

    t_result pending_results[$];
    int      n_err = 0;
    int      n_sent = 0;
    int      cycle_cnt = 0;
    bit      tx_idle = 1'b1;
    bit      rx_idle = 1'b1;
    int      rx_hold = 0;

    function automatic t_result deframe_byte(input logic [7:0] b);
        t_result r;
        r.event_res = EV_NONE;
        r.data_byte = 8'd0;
        case (dfr_phase)
            PH_HUNT: begin
                if (b == cfg_start) begin
                    dfr_phase = PH_HEADER;
                    hdr_cnt = HDR_STATUS;
                    sum_acc = 8'd0;
                end
            end
            PH_HEADER: begin
                sum_acc = sum_acc + b;
                case (hdr_cnt)
                    HDR_STATUS: begin
                        hold_status = b;
                        hdr_cnt = HDR_TYPE;
                    end
                    HDR_TYPE: begin
                        hold_type = b;
                        hdr_cnt = HDR_LENGTH;
                    end
                    default: begin
                        hdr_cnt = HDR_STATUS;
                        if (b != cfg_len) begin
                            r.event_res = EV_LENBAD;
                            dfr_phase = PH_HUNT;
                        end else begin
                            pay_cnt = 8'd0;
                            // empty payload goes straight to the checksum
                            if (b == 8'd0) dfr_phase = PH_CHECK;
                            else dfr_phase = PH_DATA;
                        end
                    end
                endcase
            end
            PH_DATA: begin
                sum_acc = sum_acc + b;
                r.event_res = EV_DATA;
                r.data_byte = b;
                pay_cnt = pay_cnt + 8'd1;
                // live length compare; count wraps if length was lowered under it
                if (pay_cnt == cfg_len) dfr_phase = PH_CHECK;
            end
            PH_CHECK: begin
                if (b == sum_acc) begin
                    dfr_phase = PH_END;
                end else begin
                    r.event_res = EV_SUMBAD;
                    dfr_phase = PH_HUNT;
                end
            end
            PH_END: begin
                r.event_res = (b == cfg_end) ? EV_GOOD : EV_ENDBAD;
                dfr_phase = PH_HUNT;
            end
            default: dfr_phase = PH_HUNT;
        endcase
        r.frame_type = hold_type;
        r.status_byte = hold_status;
        return r;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_idle ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(deframe_byte(b));
        n_sent++;
    endtask

    // start, header, payload, checksum, end; checksum or end byte optionally corrupted
    task automatic send_frame(input logic [7:0] st, input logic [7:0] ty, input logic [7:0] len,
                              input int n_pay, input bit bad_sum, input bit bad_end);
        logic [7:0] csum;
        logic [7:0] b;
        csum = st + ty + len;
        send_byte(cfg_start);
        send_byte(st);
        send_byte(ty);
        send_byte(len);
        repeat (n_pay) begin
            b = 8'($urandom);
            csum = csum + b;
            send_byte(b);
        end
        send_byte(bad_sum ? csum ^ 8'($urandom_range(1, 255)) : csum);
        send_byte(bad_end ? cfg_end ^ 8'($urandom_range(1, 255)) : cfg_end);
    endtask

    task automatic wait_idle;
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [7:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_EXP_LEN: cfg_len = val;
            CFG_START:   cfg_start = val;
            CFG_END:     cfg_end = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic check_field(input string fname, input logic [7:0] exp_v,
                               input logic [7:0] got_v);
        if (got_v !== exp_v) begin
            n_err++;
            if (n_err <= REPORT_LIMIT)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, exp_v, got_v);
        end
    endtask

    // receiver: random stalls per beat, plus an optional long hold-off
    initial begin
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold > 0) begin
                i_out_ready <= 1'b0;
                repeat (rx_hold) @(posedge i_clk);
                rx_hold = 0;
            end
            stall = rx_idle ? $urandom_range(0, 14) : 0;
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                n_err++;
                if (n_err <= REPORT_LIMIT)
                    $display("%0t: result beat with nothing expected, expected none, got event %0d",
                             $time, o_event_res);
            end else begin
                exp_r = pending_results.pop_front();
                check_field("event_res", 8'(exp_r.event_res), 8'(o_event_res));
                check_field("data_byte", exp_r.data_byte, o_data_byte);
                check_field("frame_type", exp_r.frame_type, o_frame_type);
                check_field("status_byte", exp_r.status_byte, o_status_byte);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("stx_etx_packet_deframer_unit_tb: FAIL");
            $finish;
        end
    end

    // reset registers: length 255 means a one-byte length field mismatches
    task automatic test_reset_state;
        send_frame(8'h5A, 8'hA5, 8'h01, 0, 1'b0, 1'b0);
        wait_idle;
    endtask

    task automatic test_frame_outcomes;
        write_cfg(CFG_EXP_LEN, 8'd1);
        write_cfg(CFG_START, 8'hFF);
        write_cfg(CFG_END, 8'h00);
        write_cfg(CFG_UNUSED, 8'hAB);   // must be ignored
        send_frame(8'h00, 8'hFF, 8'd1, 1, 1'b0, 1'b0);
        send_frame(8'hFF, 8'h00, 8'd1, 1, 1'b1, 1'b0);
        send_frame(8'h12, 8'h34, 8'd1, 1, 1'b0, 1'b1);
        wait_idle;
    endtask

    task automatic test_zero_length;
        write_cfg(CFG_EXP_LEN, 8'd0);
        write_cfg(CFG_START, 8'h00);
        write_cfg(CFG_END, 8'hFF);
        send_frame(8'h80, 8'h7F, 8'd0, 0, 1'b0, 1'b0);
        send_frame(8'h01, 8'h02, 8'd3, 0, 1'b0, 1'b0);
        wait_idle;
    endtask

    // length register changed while a payload is in progress
    task automatic test_live_length_change;
        logic [7:0] csum;
        logic [7:0] b;
        write_cfg(CFG_EXP_LEN, 8'd5);
        csum = 8'h11 + 8'h22 + 8'd5;
        send_byte(cfg_start);
        send_byte(8'h11);
        send_byte(8'h22);
        send_byte(8'd5);
        repeat (2) begin
            b = 8'($urandom);
            csum = csum + b;
            send_byte(b);
        end
        wait_idle;
        write_cfg(CFG_EXP_LEN, 8'd4);
        repeat (2) begin
            b = 8'($urandom);
            csum = csum + b;
            send_byte(b);
        end
        send_byte(csum);
        send_byte(cfg_end);
        wait_idle;
        // lowered below the count: it has to wrap round before it matches
        write_cfg(CFG_EXP_LEN, 8'd3);
        csum = 8'h33 + 8'h44 + 8'd3;
        send_byte(cfg_start);
        send_byte(8'h33);
        send_byte(8'h44);
        send_byte(8'd3);
        repeat (2) begin
            b = 8'($urandom);
            csum = csum + b;
            send_byte(b);
        end
        wait_idle;
        write_cfg(CFG_EXP_LEN, 8'd1);
        repeat (255) begin
            b = 8'($urandom);
            csum = csum + b;
            send_byte(b);
        end
        send_byte(csum);
        send_byte(cfg_end);
        wait_idle;
    endtask

    // receiver holds off while the sender streams back to back
    task automatic test_backpressure;
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        rx_hold = 300;
        repeat (10) send_frame(8'($urandom), 8'($urandom), cfg_len, int'(cfg_len), 1'b0, 1'b0);
        wait_idle;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    task automatic test_random_traffic;
        int first_n;
        int phase_n;
        int n_phase;
        int kind;
        int pick;
        logic [7:0] len_v;
        first_n = n_sent;
        n_phase = 0;
        while (n_sent - first_n < RAND_ITEMS) begin
            wait_idle;
            pick = $urandom_range(0, 15);
            if (n_phase == 0 || pick == 1) len_v = 8'd255;
            else if (n_phase == 1 || pick == 0) len_v = 8'd0;
            else len_v = 8'($urandom_range(1, 8));
            write_cfg(CFG_EXP_LEN, len_v);
            if (n_phase == 0) begin
                write_cfg(CFG_START, 8'h00);
                write_cfg(CFG_END, 8'hFF);
            end else begin
                write_cfg(CFG_START, 8'($urandom));
                write_cfg(CFG_END, ($urandom_range(0, 3) == 0) ? cfg_start : 8'($urandom));
            end
            if ($urandom_range(0, 3) == 0) write_cfg(CFG_UNUSED, 8'($urandom));
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            phase_n = n_sent;
            while (n_sent - phase_n < PHASE_ITEMS) begin
                kind = $urandom_range(0, 9);
                case (kind)
                    6: send_frame(8'($urandom), 8'($urandom), cfg_len, int'(cfg_len),
                                  1'b1, 1'b0);
                    7: send_frame(8'($urandom), 8'($urandom), cfg_len, int'(cfg_len),
                                  1'b0, 1'b1);
                    8: send_frame(8'($urandom), 8'($urandom),
                                  cfg_len ^ 8'($urandom_range(1, 255)),
                                  $urandom_range(0, 3), 1'b0, 1'b0);
                    9: repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
                    default: send_frame(8'($urandom), 8'($urandom), cfg_len, int'(cfg_len),
                                        1'b0, 1'b0);
                endcase
            end
            n_phase++;
        end
        wait_idle;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state;
        test_frame_outcomes;
        test_zero_length;
        test_live_length_change;
        test_backpressure;
        test_random_traffic;
        wait_idle;
        repeat (10) @(posedge i_clk);
        if (n_err == 0) begin
            $display("stx_etx_packet_deframer_unit_tb: PASS");
        end else begin
            $display("stx_etx_packet_deframer_unit_tb: FAIL");
        end
        $finish;
    end

endmodule
